FILE: hw/rtl/stick_deadzone_steering_macros.svh
// Assertion macros shared by the checker files of stick_deadzone_steering.
// No dependencies; take in with `include before use.
`ifndef STICK_DEADZONE_STEERING_MACROS_SVH
`define STICK_DEADZONE_STEERING_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define SDS_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define SDS_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/sds_pkg.sv
// Package for stick_deadzone_steering: widths, constants, register codes
// and the structs passed between lane, divider and merge modules. No dependencies.
package sds_pkg;

  localparam int AXW   = 15;           // deadzone-relative magnitude width
  localparam int QW    = 15;           // quotient width, 24831 < 2**15
  localparam int DENW  = 3 * AXW;      // d**3
  localparam int NUMW  = DENW + QW;    // m**3 * 24831
  localparam int PLW   = 23;           // low slice of the partial products
  localparam int PHW   = DENW - PLW;   // high slice

  localparam int FRONT_STAGES = 5;
  localparam int DIV_STAGES   = QW;
  localparam int PIPE_DEPTH   = FRONT_STAGES + DIV_STAGES;

  localparam logic [AXW-1:0] STICK_MAX = 15'h7FFF;
  localparam logic [QW-1:0]  WHEEL_MAX = 15'd24831;
  localparam int             TRIG_SHIFT = 8;

  typedef logic [7:0] cfg_idx_t;

  localparam cfg_idx_t REG_SINGLE_STICK   = 8'd0;
  localparam cfg_idx_t REG_LINEAR_MODE    = 8'd1;
  localparam cfg_idx_t REG_LEFT_DEADZONE  = 8'd2;
  localparam cfg_idx_t REG_RIGHT_DEADZONE = 8'd3;

  typedef struct packed {
    logic [NUMW-1:0] num;
    logic [DENW-1:0] den;
    logic            neg;
  } lane_frac_t;

  typedef struct packed {
    logic [QW-1:0] quo;
    logic          neg;
  } lane_res_t;

endpackage

FILE: hw/rtl/sds_shape.sv
// One lane front end: deadzone, clip, powers and scaling into a fraction num/den.
// Depends on sds_pkg. Five register stages.
module sds_shape (
  input  logic                    clk,
  input  logic signed [15:0]      axis,
  input  logic [14:0]             dz,
  input  logic                    linear,
  output sds_pkg::lane_frac_t     frac
);
  import sds_pkg::*;

  logic [15:0]    mag;
  logic [AXW-1:0] mag_clip;
  logic           pass;
  logic [AXW-1:0] m_nxt, d_nxt;

  logic [AXW-1:0]    s1_m_r, s1_d_r;
  logic              s1_neg_r;
  logic [2*AXW-1:0]  s2_mm_r, s2_dd_r;
  logic [AXW-1:0]    s2_m_r, s2_d_r;
  logic              s2_neg_r;
  logic [DENW-1:0]   s3_x_r, s3_den_r;
  logic              s3_neg_r;
  logic [PLW+QW-1:0] s4_pl_r;
  logic [PHW+QW-1:0] s4_ph_r;
  logic [DENW-1:0]   s4_den_r;
  logic              s4_neg_r;
  lane_frac_t        s5_r;

  always_comb begin
    mag      = axis[15] ? 16'(-axis) : 16'(axis);
    mag_clip = mag[15] ? STICK_MAX : mag[AXW-1:0];
    pass     = mag > {1'b0, dz};
    m_nxt    = mag_clip - dz;
    d_nxt    = STICK_MAX - dz;
    // force 0/1 for values inside the deadzone and for a full deadzone
    if (!pass || d_nxt == '0) begin
      m_nxt = '0;
      d_nxt = AXW'(1);
    end
  end

  always_ff @(posedge clk) begin
    s1_m_r   <= m_nxt;
    s1_d_r   <= d_nxt;
    s1_neg_r <= axis[15];

    s2_mm_r  <= (2*AXW)'(s1_m_r) * (2*AXW)'(s1_m_r);
    s2_dd_r  <= (2*AXW)'(s1_d_r) * (2*AXW)'(s1_d_r);
    s2_m_r   <= s1_m_r;
    s2_d_r   <= s1_d_r;
    s2_neg_r <= s1_neg_r;

    s3_x_r   <= linear ? DENW'(s2_m_r) : DENW'(s2_mm_r) * DENW'(s2_m_r);
    s3_den_r <= linear ? DENW'(s2_d_r) : DENW'(s2_dd_r) * DENW'(s2_d_r);
    s3_neg_r <= s2_neg_r;

    // split the scale multiply into two narrow partial products
    s4_pl_r  <= (PLW+QW)'(s3_x_r[PLW-1:0]) * (PLW+QW)'(WHEEL_MAX);
    s4_ph_r  <= (PHW+QW)'(s3_x_r[DENW-1:PLW]) * (PHW+QW)'(WHEEL_MAX);
    s4_den_r <= s3_den_r;
    s4_neg_r <= s3_neg_r;

    s5_r.num <= {s4_ph_r, {PLW{1'b0}}} + NUMW'(s4_pl_r);
    s5_r.den <= s4_den_r;
    s5_r.neg <= s4_neg_r;
  end

  assign frac = s5_r;

endmodule

FILE: hw/rtl/sds_div.sv
// Pipelined restoring divider for one lane, one quotient bit per stage.
// Depends on sds_pkg. The numerator never exceeds 24831 times the denominator.
module sds_div (
  input  logic                 clk,
  input  sds_pkg::lane_frac_t  frac,
  output sds_pkg::lane_res_t   res
);
  import sds_pkg::*;

  logic [NUMW-1:0] rem_r [QW];
  logic [DENW-1:0] den_r [QW];
  logic [QW-1:0]   quo_r [QW];
  logic            neg_r [QW];

  for (genvar i = 0; i < QW; i++) begin : g_stage
    localparam int BIT = QW - 1 - i;
    logic [NUMW-1:0] rem_in, dsh, rem_nxt;
    logic [DENW-1:0] den_in;
    logic [QW-1:0]   quo_in, quo_nxt;
    logic            neg_in, ge;

    if (i == 0) begin : g_first
      assign rem_in = frac.num;
      assign den_in = frac.den;
      assign quo_in = '0;
      assign neg_in = frac.neg;
    end else begin : g_next
      assign rem_in = rem_r[i-1];
      assign den_in = den_r[i-1];
      assign quo_in = quo_r[i-1];
      assign neg_in = neg_r[i-1];
    end

    assign dsh     = NUMW'(den_in) << BIT;
    assign ge      = rem_in >= dsh;
    assign rem_nxt = ge ? rem_in - dsh : rem_in;
    assign quo_nxt = quo_in | (QW'(ge) << BIT);

    always_ff @(posedge clk) begin
      rem_r[i] <= rem_nxt;
      den_r[i] <= den_in;
      quo_r[i] <= quo_nxt;
      neg_r[i] <= neg_in;
    end
  end

  assign res.quo = quo_r[QW-1];
  assign res.neg = neg_r[QW-1];

endmodule

FILE: hw/rtl/sds_merge.sv
// Merge stage: signs both lane results, forms the wheel value and registers
// the result item. Depends on sds_pkg.
module sds_merge (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                vld,
  input  logic                single_stick,
  input  sds_pkg::lane_res_t  left_res,
  input  sds_pkg::lane_res_t  right_res,
  input  logic [7:0]          left_trig,
  input  logic [7:0]          right_trig,
  output logic                out_valid,
  output logic signed [15:0]  out_wheel,
  output logic [15:0]         out_accel,
  output logic [15:0]         out_brake
);
  import sds_pkg::*;

  logic [15:0]        l_mag, r_mag;
  logic signed [15:0] l_val, r_val;
  logic signed [16:0] sum, sum_adj, half;
  logic signed [15:0] wheel_nxt;

  logic               valid_r;
  logic signed [15:0] wheel_r;
  logic [15:0]        accel_r, brake_r;

  always_comb begin
    l_mag     = {1'b0, left_res.quo};
    r_mag     = {1'b0, right_res.quo};
    l_val     = left_res.neg  ? $signed(~l_mag + 16'd1) : $signed(l_mag);
    r_val     = right_res.neg ? $signed(~r_mag + 16'd1) : $signed(r_mag);
    sum       = {l_val[15], l_val} + {r_val[15], r_val};
    // round toward zero before the halving shift
    sum_adj   = sum + $signed({16'd0, sum[16]});
    half      = sum_adj >>> 1;
    wheel_nxt = single_stick ? l_val : half[15:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= vld;
    end
  end

  always_ff @(posedge clk) begin
    wheel_r <= wheel_nxt;
    accel_r <= {right_trig, {TRIG_SHIFT{1'b0}}};
    brake_r <= {left_trig, {TRIG_SHIFT{1'b0}}};
  end

  assign out_valid = valid_r;
  assign out_wheel = wheel_r;
  assign out_accel = accel_r;
  assign out_brake = brake_r;

endmodule

FILE: hw/rtl/stick_deadzone_steering.sv
// Stick to steering converter: deadzone per axis plus linear or cubic response.
// Depends on sds_pkg, sds_shape, sds_div and sds_merge.
//
// Input channel: an item is taken at a clock edge with start high and busy
// low. busy stays low: a new item may be taken every cycle.
// Result channel: out_valid is high for one cycle with out_wheel, out_accel
// and out_brake; the receiver cannot stall, so the pipeline never holds.
// Pipeline: 21 register stages (five front-end stages with the power and
// scale multipliers, 15 divider stages at one quotient bit each, and the
// output register). Throughput: one item per cycle.
// Configuration: cfg_ready is always high; a write with cfg_valid updates
// the register named by cfg_index, unknown indexes are dropped. Write only
// while no item is in flight.
// Reset (rst_n low, synchronous) clears the configuration registers and the
// valid bits to 0 and drops every item in flight; no result strobe follows.
module stick_deadzone_steering (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic signed [15:0] in_left_x,
  input  logic signed [15:0] in_right_x,
  input  logic [7:0]         in_left_trigger,
  input  logic [7:0]         in_right_trigger,
  output logic               out_valid,
  output logic signed [15:0] out_wheel,
  output logic [15:0]        out_accel,
  output logic [15:0]        out_brake,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  sds_pkg::cfg_idx_t  cfg_index,
  input  logic [15:0]        cfg_data
);
  import sds_pkg::*;

  logic           single_stick_r, linear_mode_r;
  logic [AXW-1:0] left_dz_r, right_dz_r;
  logic           in_fire;

  logic       vld_r   [PIPE_DEPTH];
  logic [7:0] ltrig_r [PIPE_DEPTH];
  logic [7:0] rtrig_r [PIPE_DEPTH];

  lane_frac_t left_frac, right_frac;
  lane_res_t  left_res, right_res;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;
  assign in_fire   = start && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      single_stick_r <= 1'b0;
      linear_mode_r  <= 1'b0;
      left_dz_r      <= '0;
      right_dz_r     <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_SINGLE_STICK:   single_stick_r <= cfg_data[0];
        REG_LINEAR_MODE:    linear_mode_r  <= cfg_data[0];
        REG_LEFT_DEADZONE:  left_dz_r      <= cfg_data[AXW-1:0];
        REG_RIGHT_DEADZONE: right_dz_r     <= cfg_data[AXW-1:0];
        default: ;
      endcase
    end
  end

  // valid and trigger bytes travel alongside the lane pipelines
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < PIPE_DEPTH; i++) vld_r[i] <= 1'b0;
    end else begin
      vld_r[0] <= in_fire;
      for (int i = 1; i < PIPE_DEPTH; i++) vld_r[i] <= vld_r[i-1];
    end
  end

  always_ff @(posedge clk) begin
    ltrig_r[0] <= in_left_trigger;
    rtrig_r[0] <= in_right_trigger;
    for (int i = 1; i < PIPE_DEPTH; i++) begin
      ltrig_r[i] <= ltrig_r[i-1];
      rtrig_r[i] <= rtrig_r[i-1];
    end
  end

  sds_shape u_shape_left (
    .clk    (clk),
    .axis   (in_left_x),
    .dz     (left_dz_r),
    .linear (linear_mode_r),
    .frac   (left_frac)
  );

  sds_shape u_shape_right (
    .clk    (clk),
    .axis   (in_right_x),
    .dz     (right_dz_r),
    .linear (linear_mode_r),
    .frac   (right_frac)
  );

  sds_div u_div_left (
    .clk  (clk),
    .frac (left_frac),
    .res  (left_res)
  );

  sds_div u_div_right (
    .clk  (clk),
    .frac (right_frac),
    .res  (right_res)
  );

  sds_merge u_merge (
    .clk          (clk),
    .rst_n        (rst_n),
    .vld          (vld_r[PIPE_DEPTH-1]),
    .single_stick (single_stick_r),
    .left_res     (left_res),
    .right_res    (right_res),
    .left_trig    (ltrig_r[PIPE_DEPTH-1]),
    .right_trig   (rtrig_r[PIPE_DEPTH-1]),
    .out_valid    (out_valid),
    .out_wheel    (out_wheel),
    .out_accel    (out_accel),
    .out_brake    (out_brake)
  );

endmodule

FILE: hw/rtl/sds_checker.sv
// Port-level checker for stick_deadzone_steering, bound to the top level.
// Depends on stick_deadzone_steering_macros.svh.
`include "stick_deadzone_steering_macros.svh"

module sds_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               start,
  input logic               busy,
  input logic [7:0]         in_left_trigger,
  input logic [7:0]         in_right_trigger,
  input logic               out_valid,
  input logic signed [15:0] out_wheel,
  input logic [15:0]        out_accel,
  input logic [15:0]        out_brake
);

  // every accepted item is followed by its result strobe
  `SDS_ASSERT_IMP(a_item_out, clk, rst_n, start && !busy, ##21 out_valid, "item result missing")

  // no result strobe without a matching accepted item
  `SDS_ASSERT_IMP(a_no_phantom, clk, rst_n, out_valid, $past(start && !busy, 21), "result without item")

  // triggers reach accel and brake shifted by eight
  `SDS_ASSERT_IMP(a_trig_path, clk, rst_n, out_valid, out_accel[15:8] == $past(in_right_trigger, 21) && out_accel[7:0] == 8'd0 && out_brake[15:8] == $past(in_left_trigger, 21) && out_brake[7:0] == 8'd0, "trigger value mismatch")

  // wheel stays within full scale
  `SDS_ASSERT_IMP(a_wheel_range, clk, rst_n, out_valid, out_wheel <= 16'sd24831 && out_wheel >= -16'sd24831, "wheel out of range")

endmodule

bind stick_deadzone_steering sds_checker u_sds_checker (.*);
